// ===== rtl/mdio_controller_with_c45_phy_assert.svh =====
// Assertion macros shared by the checker files of the MDIO controller.
// Depends on nothing; include with the bare file name.
`ifndef MDIO_CONTROLLER_WITH_C45_PHY_ASSERT_SVH
`define MDIO_CONTROLLER_WITH_C45_PHY_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MDIOC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MDIOC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/mdioc_pkg.sv =====
// Package for the MDIO controller: window decode constants and PHY register table.
// Depends on nothing.
package mdioc_pkg;

	// Access kinds.
	localparam logic FUNC_READ  = 1'b0;
	localparam logic FUNC_WRITE = 1'b1;

	// Register window: four words at byte offset 0x1c00.
	localparam logic [11:0] WIN_BASE_HI = 12'h1c0;
	localparam logic [1:0]  REG_CONFIG  = 2'd0;
	localparam logic [1:0]  REG_CONTROL = 2'd1;
	localparam logic [1:0]  REG_DATA    = 2'd2;
	localparam logic [1:0]  REG_ADDRESS = 2'd3;

	// Config and control bit positions.
	localparam int CFG_BUSY_BIT  = 0;
	localparam int CFG_RDERR_BIT = 1;
	localparam int CTL_READ_BIT  = 15;

	localparam logic [4:0]  PHY_PORT_RESET = 5'd8;
	localparam logic [31:0] DATA_ERROR     = 32'h0000_ffff;

	// Clause-45 device codes.
	localparam logic [4:0] DEV_PMA    = 5'd1;
	localparam logic [4:0] DEV_PCS    = 5'd3;
	localparam logic [4:0] DEV_PHYXS  = 5'd4;
	localparam logic [4:0] DEV_AN     = 5'd7;
	localparam logic [4:0] DEV_VENDOR = 5'd30;

	// One accepted request as seen by the register file.
	typedef struct packed {
		logic        fire;
		logic        func;
		logic [15:0] offset;
		logic [31:0] write_data;
	} access_t;

	// Fixed PHY register table, keyed by device and register address.
	function automatic logic [15:0] phy_lookup(input logic [4:0] dev,
		input logic [15:0] regaddr);
		logic        pma;
		logic [15:0] val;
		pma = (dev == DEV_PMA);
		val = 16'h0000;
		if (dev == DEV_VENDOR) begin
			if (regaddr == 16'h0020) begin
				val = 16'h0501;
			end else if (regaddr >= 16'h031a && regaddr < 16'h031f) begin
				val = 16'h0003;
			end
		end else begin
			unique case (regaddr)
				16'h0006: val = 16'h009a;
				16'h0005: val = 16'hc000;
				16'h0002: val = 16'h31c3;
				16'h0003: val = 16'h1c12;
				16'h0008: val = pma ? (16'h8000 | 16'h0200) : 16'h8000;
				16'h000b: val = pma ? (16'h0004 | 16'h4000) : 16'h0000;
				16'h0015: val = pma ? 16'h0003 : 16'h0000;
				16'h0001: begin
					if (dev == DEV_PMA || dev == DEV_PCS || dev == DEV_PHYXS
						|| dev == DEV_AN) begin
						val = 16'h0004;
					end
				end
				default: val = 16'h0000;
			endcase
		end
		return val;
	endfunction

endpackage

// ===== rtl/mdioc_if.sv =====
// Valid/ready channel interfaces for bus requests and read responses.
// Depends on nothing.
interface mdioc_req_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [15:0] offset;
	logic [31:0] write_data;

	modport source(output valid, func, offset, write_data, input ready);
	modport sink(input valid, func, offset, write_data, output ready);
endinterface

interface mdioc_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] read_data;

	modport source(output valid, read_data, input ready);
	modport sink(input valid, read_data, output ready);
endinterface

// ===== rtl/mdio_controller_with_c45_phy.sv =====
// MDIO controller with embedded clause-45 PHY: one request per cycle.
// A read result passes through the input register and then the result register,
// and can wait in the input register while the response is stalled; writes give
// no result.
// Throughput is one request per cycle; only a stalled response holds the input.
// Reset clears all window registers to zero and the PHY port address to 8.
module mdio_controller_with_c45_phy (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [4:0]         cfg_wdata,
	mdioc_req_if.sink          req,
	mdioc_rsp_if.source        rsp
);

	logic        req_valid_s1;
	logic        req_func_s1;
	logic [15:0] req_offset_s1;
	logic [31:0] req_wdata_s1;
	logic        rsp_valid_q;
	logic [31:0] rsp_data_q;

	logic               s1_is_read;
	logic               s1_adv;
	logic [31:0]        rd_data;
	mdioc_pkg::access_t acc;

	// A read leaves the input stage only when the result register can take it.
	assign s1_is_read = req_valid_s1 && (req_func_s1 == mdioc_pkg::FUNC_READ);
	assign s1_adv     = req_valid_s1 && (!s1_is_read || !rsp_valid_q || rsp.ready);
	assign req.ready  = !req_valid_s1 || s1_adv;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (req.valid && req.ready) begin
			req_valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			req_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_func_s1   <= req.func;
			req_offset_s1 <= req.offset;
			req_wdata_s1  <= req.write_data;
		end
	end

	assign acc.fire       = s1_adv;
	assign acc.func       = req_func_s1;
	assign acc.offset     = req_offset_s1;
	assign acc.write_data = req_wdata_s1;

	mdioc_regfile u_regfile (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.acc       (acc),
		.read_data (rd_data)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_adv && s1_is_read) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && s1_is_read) begin
			rsp_data_q <= rd_data;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.read_data = rsp_data_q;

endmodule

// ===== rtl/mdioc_regfile.sv =====
// Register window state, decode and control-word handling with the PHY table.
// Depends on mdioc_pkg.
module mdioc_regfile (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [4:0]           cfg_wdata,
	input  mdioc_pkg::access_t   acc,
	output logic [31:0]          read_data
);

	logic [4:0]  phy_port_q;
	logic [31:0] config_word_q;
	logic [31:0] control_word_q;
	logic [31:0] data_word_q;
	logic [31:0] phy_addr_q;

	logic        in_window;
	logic [1:0]  reg_sel;
	logic        port_match;
	logic        rd_error;
	logic [15:0] phy_value;

	// Window decode: aligned words in 0x1c00..0x1c0f only.
	assign in_window = (acc.offset[15:4] == mdioc_pkg::WIN_BASE_HI)
		&& (acc.offset[1:0] == 2'b00);
	assign reg_sel   = acc.offset[3:2];

	// Read mux; config never shows busy.
	always_comb begin
		read_data = 32'h0;
		if (in_window) begin
			unique case (reg_sel)
				mdioc_pkg::REG_CONFIG: begin
					read_data = config_word_q;
					read_data[mdioc_pkg::CFG_BUSY_BIT] = 1'b0;
				end
				mdioc_pkg::REG_CONTROL: read_data = control_word_q;
				mdioc_pkg::REG_DATA:    read_data = data_word_q;
				mdioc_pkg::REG_ADDRESS: read_data = phy_addr_q;
				default:                read_data = 32'h0;
			endcase
		end
	end

	// PHY response for a control write.
	assign port_match = (acc.write_data[9:5] == phy_port_q);
	assign rd_error   = acc.write_data[mdioc_pkg::CTL_READ_BIT] && !port_match;
	assign phy_value  = mdioc_pkg::phy_lookup(acc.write_data[4:0], phy_addr_q[15:0]);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phy_port_q <= mdioc_pkg::PHY_PORT_RESET;
		end else if (cfg_we) begin
			phy_port_q <= cfg_wdata;
		end
	end

	// Window writes; a control write updates the read error flag and may run a PHY read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			config_word_q  <= 32'h0;
			control_word_q <= 32'h0;
			data_word_q    <= 32'h0;
			phy_addr_q     <= 32'h0;
		end else if (acc.fire && acc.func == mdioc_pkg::FUNC_WRITE && in_window) begin
			unique case (reg_sel)
				mdioc_pkg::REG_CONFIG:  config_word_q <= acc.write_data;
				mdioc_pkg::REG_CONTROL: begin
					// A control write sets the error flag only for a read to a foreign port.
					control_word_q <= acc.write_data;
					config_word_q[mdioc_pkg::CFG_RDERR_BIT] <= rd_error;
					if (acc.write_data[mdioc_pkg::CTL_READ_BIT]) begin
						data_word_q <= port_match ? {16'h0000, phy_value}
							: mdioc_pkg::DATA_ERROR;
					end
				end
				mdioc_pkg::REG_DATA:    data_word_q <= acc.write_data;
				mdioc_pkg::REG_ADDRESS: phy_addr_q <= acc.write_data;
				default:                data_word_q <= data_word_q;
			endcase
		end
	end

endmodule

// ===== rtl/mdioc_checker.sv =====
// Port-level checks for the MDIO controller, bound to the top level.
// Depends on mdioc_pkg and the assertion macro header.
`include "mdio_controller_with_c45_phy_assert.svh"

module mdioc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        req_func,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [31:0] rsp_read_data
);

	// A held response keeps its valid and its data.
	`MDIOC_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")
	`MDIOC_ASSERT_NEXT(a_rsp_stable, clk, arst_n, rsp_valid && !rsp_ready, $stable(rsp_read_data), "response data changed while stalled")

	// The request side stalls only behind a stalled response.
	`MDIOC_ASSERT_IMPL(a_stall_cause, clk, arst_n, !req_ready, rsp_valid && !rsp_ready, "request stalled without output backpressure")

	// With the output empty, an accepted read shows a result once it has passed the input and result registers.
	`MDIOC_ASSERT_NEXT(a_read_latency, clk, arst_n, req_valid && req_ready && (req_func == mdioc_pkg::FUNC_READ) && !rsp_valid, ##1 rsp_valid, "read result missing")

endmodule

bind mdio_controller_with_c45_phy mdioc_checker u_mdioc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.req_func      (req.func),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_read_data (rsp.read_data)
);
